[rtl/ced_pkg.sv]
// ----------------------------------------------------------------------------
// ced_pkg: shared types and constants of the cascaded exponential damper
// command codes, controller states, datapath command/status structs
// ----------------------------------------------------------------------------
package ced_pkg;

   localparam int STAGES_DEF     = 5;
   localparam int VALUE_BITS_DEF = 32;
   localparam int RATIO_FRAC     = 12;
   localparam logic [30:0] SETTLE_FLOOR = 31'd66;

   typedef enum logic [1:0] {
      OP_TICK       = 2'd0,
      OP_SET_TARGET = 2'd1,
      OP_SET_VALUE  = 2'd2,
      OP_NONE       = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      REG_ORDER   = 3'd0,
      REG_TAU     = 3'd1,
      REG_TOL     = 3'd2,
      REG_START_X = 3'd3,
      REG_START_Y = 3'd4,
      REG_START_Z = 3'd5
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_EXP,
      ST_BLEND_MUL,
      ST_BLEND_ADD,
      ST_CHECK_SUB,
      ST_CHECK_MUL,
      ST_CHECK_CMP,
      ST_FINISH,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_item;     // capture input word
      logic set_target;
      logic overwrite;     // load position into every stage and output
      logic mark_time;     // record the time of each active tick
      logic div_start;
      logic div_step;
      logic exp_step;
      logic blend_mul;
      logic blend_add;
      logic check_sub;
      logic check_mul;
      logic snap;
      logic copy_out;
      logic stage_next;
      logic set_active;
      logic clr_active;
      logic set_event;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic op_tick;
      logic op_set_target;
      logic op_overwrite;
      logic target_diff;
      logic active;
      logic time_seen;
      logic tau_zero;
      logic div_last;
      logic exp_last;
      logic stage_last;
      logic link_short;
      logic check_last;
   } status_type;

   function automatic logic [15:0] exp_tab(input logic [3:0] k);
      logic [15:0] v;
      case (k)
         4'd0:  v = 16'd65520;
         4'd1:  v = 16'd65504;
         4'd2:  v = 16'd65472;
         4'd3:  v = 16'd65408;
         4'd4:  v = 16'd65280;
         4'd5:  v = 16'd65026;
         4'd6:  v = 16'd64520;
         4'd7:  v = 16'd63520;
         4'd8:  v = 16'd61565;
         4'd9:  v = 16'd57835;
         4'd10: v = 16'd51039;
         4'd11: v = 16'd39750;
         4'd12: v = 16'd24109;
         4'd13: v = 16'd8869;
         4'd14: v = 16'd1200;
         default: v = 16'd22;
      endcase
      return v;
   endfunction

endpackage

[rtl/ced_if.sv]
// ----------------------------------------------------------------------------
// ced channel interfaces
// request, response and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface ced_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [31:0] pos_x;
   logic [31:0] pos_y;
   logic [31:0] pos_z;
   logic [31:0] timestamp;
   modport source (output valid, opcode, pos_x, pos_y, pos_z, timestamp, input ready);
   modport sink   (input valid, opcode, pos_x, pos_y, pos_z, timestamp, output ready);
endinterface

interface ced_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_x;
   logic [31:0] out_y;
   logic [31:0] out_z;
   logic        is_active;
   logic        value_event;
   modport source (output valid, out_x, out_y, out_z, is_active, value_event, input ready);
   modport sink   (input valid, out_x, out_y, out_z, is_active, value_event, output ready);
endinterface

interface ced_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/ced_ctrl.sv]
// ----------------------------------------------------------------------------
// ced_ctrl: sequencer for one word
// steps divider, alpha product, per-stage blend and settle check
// ----------------------------------------------------------------------------
module ced_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ced_pkg::cmd_type    cmd,
   input  ced_pkg::status_type sts
);

   ced_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ced_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ced_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in = ced_pkg::ST_FINISH;
            end
         end
         ced_pkg::ST_FINISH: begin
            // decode captured word
            state_in = ced_pkg::ST_OUT;
            if (sts.op_set_target) begin
               cmd.set_target = 1'b1;
               if (sts.target_diff) cmd.set_active = 1'b1;
            end else if (sts.op_overwrite) begin
               cmd.overwrite  = 1'b1;
               cmd.set_active = 1'b1;
               cmd.set_event  = 1'b1;
            end else if (sts.op_tick && sts.active) begin
               if (!sts.time_seen) begin
                  cmd.mark_time = 1'b1;
               end else begin
                  cmd.mark_time = 1'b1;
                  cmd.set_event = 1'b1;
                  cmd.div_start = 1'b1;
                  state_in = sts.tau_zero ? ced_pkg::ST_BLEND_MUL : ced_pkg::ST_DIV;
               end
            end
         end
         ced_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = ced_pkg::ST_EXP;
         end
         ced_pkg::ST_EXP: begin
            cmd.exp_step = 1'b1;
            if (sts.exp_last) state_in = ced_pkg::ST_BLEND_MUL;
         end
         ced_pkg::ST_BLEND_MUL: begin
            cmd.blend_mul = 1'b1;
            state_in = ced_pkg::ST_BLEND_ADD;
         end
         ced_pkg::ST_BLEND_ADD: begin
            cmd.blend_add  = 1'b1;
            cmd.stage_next = 1'b1;
            state_in = sts.stage_last ? ced_pkg::ST_CHECK_SUB : ced_pkg::ST_BLEND_MUL;
         end
         ced_pkg::ST_CHECK_SUB: begin
            cmd.check_sub = 1'b1;
            state_in = ced_pkg::ST_CHECK_MUL;
         end
         ced_pkg::ST_CHECK_MUL: begin
            cmd.check_mul = 1'b1;
            state_in = ced_pkg::ST_CHECK_CMP;
         end
         ced_pkg::ST_CHECK_CMP: begin
            cmd.stage_next = 1'b1;
            if (!sts.link_short) begin
               cmd.copy_out = 1'b1;
               state_in = ced_pkg::ST_OUT;
            end else if (sts.check_last) begin
               cmd.snap       = 1'b1;
               cmd.clr_active = 1'b1;
               state_in = ced_pkg::ST_OUT;
            end else begin
               state_in = ced_pkg::ST_CHECK_SUB;
            end
         end
         ced_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ced_pkg::ST_IDLE;
         end
         default: state_in = ced_pkg::ST_IDLE;
      endcase
   end

   a_out_no_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while result pending");
   a_snap_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.snap && cmd.copy_out)) else $error("snap and copy together");
   a_div_to_exp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ced_pkg::ST_DIV && sts.div_last) |=> state_ff == ced_pkg::ST_EXP)
      else $error("divider exit");

endmodule

[rtl/ced_dp.sv]
// ----------------------------------------------------------------------------
// ced_dp: datapath of the damper
// stage registers, restoring divider, alpha product, blend and settle check
// ----------------------------------------------------------------------------
module ced_dp #(
   parameter int STAGES     = ced_pkg::STAGES_DEF,
   parameter int VALUE_BITS = ced_pkg::VALUE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ced_pkg::cmd_type    cmd,
   output ced_pkg::status_type sts,
   input  logic [1:0]          req_opcode,
   input  logic [31:0]         req_pos_x,
   input  logic [31:0]         req_pos_y,
   input  logic [31:0]         req_pos_z,
   input  logic [31:0]         req_timestamp,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_data,
   output logic [31:0]         rsp_out_x,
   output logic [31:0]         rsp_out_y,
   output logic [31:0]         rsp_out_z,
   output logic                rsp_is_active,
   output logic                rsp_value_event
);
   localparam int VB = VALUE_BITS;
   localparam int SW = (STAGES > 1) ? $clog2(STAGES) : 1;
   localparam int CW = $clog2(STAGES + 1);
   localparam int MW = VB + 1;          // link magnitude width
   localparam int DW = 32 + ced_pkg::RATIO_FRAC;

   typedef logic signed [VB-1:0] pos_type;

   // configuration
   logic [2:0]  order_ff;
   logic [31:0] tau_ff;
   logic [30:0] tol_ff;

   // state
   pos_type stage_ff [3][STAGES];
   pos_type target_ff [3];
   pos_type out_ff [3];
   logic [31:0] last_time_ff;
   logic time_seen_ff, active_ff, event_ff;

   // captured word
   logic [1:0]  op_ff;
   pos_type     pos_ff [3];
   logic [31:0] now_ff;

   // divider and alpha
   logic [DW-1:0] quo_ff;
   logic [32:0]   rem_ff;
   logic [5:0]    cnt_ff;
   logic [16:0]   alpha_ff;

   // blend and check
   logic [SW-1:0]   idx_ff;
   logic [2:0]      neg_ff;
   logic [VB+16:0]  prod_ff [3];
   logic [MW-1:0]   lmag_ff [3];
   logic [2*MW+1:0] sq_sum_ff;
   logic            big_ff;

   logic [CW-1:0] ord_eff;
   logic [31:0]   thr;
   logic          tau_zero;

   assign ord_eff  = (CW'(order_ff) > CW'(STAGES)) ? CW'(STAGES) : CW'(order_ff);
   assign thr      = (tol_ff > ced_pkg::SETTLE_FLOOR) ? {1'b0, tol_ff}
                                                      : {1'b0, ced_pkg::SETTLE_FLOOR};
   assign tau_zero = (tau_ff == 32'd0);

   function automatic pos_type to_pos(input logic [31:0] raw);
      return pos_type'(signed'(raw));
   endfunction

   // blend source: stage before, or target for stage zero
   // difference is one bit wider so opposite extremes do not wrap
   pos_type prev_v [3];
   pos_type own_v  [3];
   logic signed [VB:0] diff_v [3];
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         own_v[a]  = stage_ff[a][idx_ff];
         prev_v[a] = (idx_ff == '0) ? target_ff[a] : stage_ff[a][idx_ff - SW'(1)];
         diff_v[a] = {own_v[a][VB-1], own_v[a]} - {prev_v[a][VB-1], prev_v[a]};
      end
   end

   logic blend_on;
   assign blend_on = (CW'(idx_ff) < ord_eff) && !tau_zero;

   logic [32:0] rem_sh;
   assign rem_sh = {rem_ff[31:0], quo_ff[DW-1]};

   logic [32:0] exp_prod;
   assign exp_prod = 33'(({16'd0, alpha_ff} * 33'(ced_pkg::exp_tab(cnt_ff[3:0]))
                     + 33'd32768) >> 16);

   // link endpoints at idx_ff
   logic signed [VB:0] link_d [3];
   always_comb begin
      for (int a = 0; a < 3; a++)
         link_d[a] = {stage_ff[a][idx_ff][VB-1], stage_ff[a][idx_ff]}
                   - {prev_v[a][VB-1], prev_v[a]};
   end

   logic [2*MW+1:0] thr_sq;
   assign thr_sq = (2*MW+2)'({32'd0, thr} * {32'd0, thr});

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff     <= 3'd3;
         tau_ff       <= 32'd300000;
         tol_ff       <= '0;
         last_time_ff <= '0;
         time_seen_ff <= 1'b0;
         active_ff    <= 1'b1;
         event_ff     <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            target_ff[a] <= '0;
            out_ff[a]    <= '0;
            for (int i = 0; i < STAGES; i++) stage_ff[a][i] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               ced_pkg::REG_ORDER: order_ff <= csr_data[2:0];
               ced_pkg::REG_TAU:   tau_ff   <= csr_data;
               ced_pkg::REG_TOL:   tol_ff   <= csr_data[30:0];
               ced_pkg::REG_START_X, ced_pkg::REG_START_Y, ced_pkg::REG_START_Z: begin
                  for (int a = 0; a < 3; a++)
                     if (csr_index == 3'(a + 3)) begin
                        out_ff[a] <= to_pos(csr_data);
                        for (int i = 0; i < STAGES; i++) stage_ff[a][i] <= to_pos(csr_data);
                     end
               end
               default: ;
            endcase
         end
         if (cmd.load_item) begin
            op_ff     <= req_opcode;
            pos_ff[0] <= to_pos(req_pos_x);
            pos_ff[1] <= to_pos(req_pos_y);
            pos_ff[2] <= to_pos(req_pos_z);
            now_ff    <= req_timestamp;
            event_ff  <= 1'b0;
         end
         if (cmd.set_target)
            for (int a = 0; a < 3; a++) target_ff[a] <= pos_ff[a];
         if (cmd.overwrite)
            for (int a = 0; a < 3; a++) begin
               out_ff[a] <= pos_ff[a];
               for (int i = 0; i < STAGES; i++) stage_ff[a][i] <= pos_ff[a];
            end
         if (cmd.mark_time) begin
            time_seen_ff <= 1'b1;
            last_time_ff <= now_ff;
         end
         if (cmd.set_active) active_ff <= 1'b1;
         if (cmd.clr_active) active_ff <= 1'b0;
         if (cmd.set_event)  event_ff  <= 1'b1;
         if (cmd.div_start) begin
            quo_ff   <= {now_ff - last_time_ff, {ced_pkg::RATIO_FRAC{1'b0}}};
            rem_ff   <= '0;
            cnt_ff   <= '0;
            idx_ff   <= '0;
            alpha_ff <= 17'd0;
         end
         if (cmd.div_step) begin
            // restoring division, one quotient bit a cycle
            if (rem_sh >= {1'b0, tau_ff}) begin
               rem_ff <= rem_sh - {1'b0, tau_ff};
               quo_ff <= {quo_ff[DW-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[DW-2:0], 1'b0};
            end
            cnt_ff <= (cnt_ff == 6'(DW - 1)) ? 6'd0 : cnt_ff + 6'd1;
            if (cnt_ff == 6'(DW - 1)) alpha_ff <= 17'd65536;
         end
         if (cmd.exp_step) begin
            if (quo_ff[DW-1:16] != '0) alpha_ff <= 17'd0;
            else if (quo_ff[cnt_ff[3:0]]) alpha_ff <= exp_prod[16:0];
            cnt_ff <= cnt_ff + 6'd1;
         end
         if (cmd.blend_mul)
            for (int a = 0; a < 3; a++) begin
               neg_ff[a]  <= diff_v[a][VB];
               prod_ff[a] <= (VB+17)'(VB'(diff_v[a][VB] ? -diff_v[a] : diff_v[a])
                             * (VB+17)'(alpha_ff));
            end
         if (cmd.blend_add)
            for (int a = 0; a < 3; a++) begin
               if (blend_on) begin
                  if (neg_ff[a])
                     stage_ff[a][idx_ff] <= prev_v[a] - pos_type'((prod_ff[a] + 32768) >> 16);
                  else
                     stage_ff[a][idx_ff] <= prev_v[a] + pos_type'((prod_ff[a] + 32768) >> 16);
               end else begin
                  stage_ff[a][idx_ff] <= prev_v[a];
               end
            end
         if (cmd.stage_next)
            idx_ff <= (CW'(idx_ff) == CW'(STAGES - 1)) ? '0 : idx_ff + SW'(1);
         if (cmd.check_sub) begin
            big_ff <= 1'b0;
            for (int a = 0; a < 3; a++) begin
               lmag_ff[a] <= link_d[a][VB] ? MW'(-link_d[a]) : MW'(link_d[a]);
               if ((link_d[a][VB] ? MW'(-link_d[a]) : MW'(link_d[a])) >= MW'(thr))
                  big_ff <= 1'b1;
            end
         end
         if (cmd.check_mul)
            sq_sum_ff <= (2*MW+2)'(lmag_ff[0] * lmag_ff[0])
                       + (2*MW+2)'(lmag_ff[1] * lmag_ff[1])
                       + (2*MW+2)'(lmag_ff[2] * lmag_ff[2]);
         if (cmd.snap)
            for (int a = 0; a < 3; a++) begin
               out_ff[a] <= target_ff[a];
               for (int i = 0; i < STAGES; i++) stage_ff[a][i] <= target_ff[a];
            end
         if (cmd.copy_out)
            for (int a = 0; a < 3; a++) out_ff[a] <= stage_ff[a][STAGES-1];
      end
   end

   // check index restarts at zero after blending wraps idx to zero
   assign sts.op_tick       = (op_ff == ced_pkg::OP_TICK);
   assign sts.op_set_target = (op_ff == ced_pkg::OP_SET_TARGET);
   assign sts.op_overwrite  = (op_ff == ced_pkg::OP_SET_VALUE);
   assign sts.target_diff   = (pos_ff[0] != target_ff[0]) || (pos_ff[1] != target_ff[1])
                            || (pos_ff[2] != target_ff[2]);
   assign sts.active        = active_ff;
   assign sts.time_seen     = time_seen_ff;
   assign sts.tau_zero      = tau_zero;
   assign sts.div_last      = (cnt_ff == 6'(DW - 1));
   assign sts.exp_last      = (cnt_ff == 6'd15) || (quo_ff[DW-1:16] != '0);
   assign sts.stage_last    = (CW'(idx_ff) == CW'(STAGES - 1));
   assign sts.link_short    = !big_ff && (sq_sum_ff < thr_sq);
   assign sts.check_last    = (CW'(idx_ff) + CW'(1) >= ord_eff);

   assign rsp_out_x       = 32'(out_ff[0]);
   assign rsp_out_y       = 32'(out_ff[1]);
   assign rsp_out_z       = 32'(out_ff[2]);
   assign rsp_is_active   = active_ff;
   assign rsp_value_event = event_ff;

   a_alpha_range: assert property (@(posedge clock) disable iff (reset)
      cmd.blend_mul |-> alpha_ff <= 17'd65536) else $error("alpha out of range");
   a_snap_inactive: assert property (@(posedge clock) disable iff (reset)
      cmd.snap |=> !active_ff) else $error("snap left block active");
   a_seen_on_event: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> time_seen_ff) else $error("update before first tick");

endmodule

[rtl/cascaded_exponential_damper_top.sv]
// ----------------------------------------------------------------------------
// cascaded_exponential_damper_top: 3-d exponential smoothing cascade
// sequencer plus datapath; one response word per request word
// ----------------------------------------------------------------------------
//  channel  | dir | handshake      | payload
//  req_     | in  | valid / ready  | opcode, pos_x/y/z, timestamp
//  rsp_     | out | valid / ready  | out_x/y/z, is_active, value_event
//  csr_     | in  | valid / ready  | index, data (always ready)
//
//  set and idle-tick words pass from accept through FINISH to OUT
//  an update tick runs FINISH, the divider, the alpha product, the blend of each
//  stage and the check of each link; tau zero skips divider and alpha
//  one word at a time: req ready only in idle, rsp held until taken
//  synchronous active-high reset loads register defaults and zero positions
// ----------------------------------------------------------------------------
module cascaded_exponential_damper_top #(
   parameter int STAGES     = ced_pkg::STAGES_DEF,
   parameter int VALUE_BITS = ced_pkg::VALUE_BITS_DEF
) (
   input logic   clock,
   input logic   reset,
   ced_req_if.sink   req,
   ced_rsp_if.source rsp,
   ced_csr_if.sink   csr
);

   ced_pkg::cmd_type    cmd;
   ced_pkg::status_type sts;

   // registers are always writable
   assign csr.ready = 1'b1;

   ced_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   ced_dp #(.STAGES(STAGES), .VALUE_BITS(VALUE_BITS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_opcode      (req.opcode),
      .req_pos_x       (req.pos_x),
      .req_pos_y       (req.pos_y),
      .req_pos_z       (req.pos_z),
      .req_timestamp   (req.timestamp),
      .csr_we          (csr.valid),
      .csr_index       (csr.index),
      .csr_data        (csr.data),
      .rsp_out_x       (rsp.out_x),
      .rsp_out_y       (rsp.out_y),
      .rsp_out_z       (rsp.out_z),
      .rsp_is_active   (rsp.is_active),
      .rsp_value_event (rsp.value_event)
   );

endmodule

[tb/cascaded_exponential_damper_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cascaded_exponential_damper_top_tb: self-checking bench for the damper
// drives set-target, set-value and tick words through the request channel,
// predicts every response word in a bit-accurate model of the cascade and
// compares it field by field; register settings change between phases
// ----------------------------------------------------------------------------
module cascaded_exponential_damper_top_tb;

   localparam int          NUM_STAGES  = 5;
   localparam int          PHASE_WORDS = 210;
   localparam int          NUM_PHASES  = 8;
   localparam int          DRAIN_WAIT  = 150;
   localparam longint      CYCLE_LIMIT = 2000000;
   localparam logic [30:0] TOL_FLOOR   = 31'd66;

   // exp(-2^(k-12)) in q0.16 for every bit k of the q4.12 time ratio
   localparam logic [15:0] DECAY_STEP [16] = '{
      16'd65520, 16'd65504, 16'd65472, 16'd65408, 16'd65280, 16'd65026,
      16'd64520, 16'd63520, 16'd61565, 16'd57835, 16'd51039, 16'd39750,
      16'd24109, 16'd8869,  16'd1200,  16'd22
   };

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        active;
      logic        moved;
   } damper_word_type;

   // one directed word, with the typed-in response where it is obvious
   typedef struct packed {
      ced_pkg::opcode_type op;
      logic [31:0]         x;
      logic [31:0]         y;
      logic [31:0]         z;
      logic [31:0]         ts;
      logic                typed;
      damper_word_type     want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   longint cycle_count = 0;
   bit failed = 1'b0;
   bit no_idle = 1'b0;

   ced_req_if req_if ();
   ced_rsp_if rsp_if ();
   ced_csr_if csr_if ();

   cascaded_exponential_damper_top i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // damper model: register copy and cascade state
   // ---------------------------------------------------------------------
   logic [2:0]  order_reg;
   logic [31:0] tau_reg;
   logic [30:0] tol_reg;
   longint      stage_pos [3][NUM_STAGES];
   longint      target_pos [3];
   longint      out_pos [3];
   logic [31:0] last_stamp;
   bit          stamp_seen;
   bit          damping_active;

   damper_word_type pending_words [$];

   function automatic void load_axis(int axis, longint v);
      for (int i = 0; i < NUM_STAGES; i++) stage_pos[axis][i] = v;
      out_pos[axis] = v;
   endfunction

   function automatic void model_reset();
      order_reg = 3'd3;
      tau_reg = 32'd300000;
      tol_reg = '0;
      for (int a = 0; a < 3; a++) begin
         target_pos[a] = 0;
         load_axis(a, 0);
      end
      last_stamp = '0;
      stamp_seen = 1'b0;
      damping_active = 1'b1;
   endfunction

   function automatic void model_write_reg(ced_pkg::reg_index_type idx, logic [31:0] data);
      case (idx)
         ced_pkg::REG_ORDER:   order_reg = data[2:0];
         ced_pkg::REG_TAU:     tau_reg = data;
         ced_pkg::REG_TOL:     tol_reg = data[30:0];
         ced_pkg::REG_START_X: load_axis(0, longint'($signed(data)));
         ced_pkg::REG_START_Y: load_axis(1, longint'($signed(data)));
         ced_pkg::REG_START_Z: load_axis(2, longint'($signed(data)));
         default: ;
      endcase
   endfunction

   // decay factor in q0.16 for an elapsed time over tau
   function automatic logic [63:0] decay_factor(logic [31:0] elapsed);
      logic [63:0] ratio;
      logic [63:0] acc;
      ratio = {20'd0, elapsed, 12'd0} / {32'd0, tau_reg};
      acc = 64'd65536;
      if (ratio >= 64'd65536) return 64'd0;
      for (int k = 0; k < 16; k++)
         if (ratio[k]) acc = (acc * DECAY_STEP[k] + 64'd32768) >> 16;
      return acc;
   endfunction

   // prev + (own - prev) * alpha, product rounded half away from zero
   function automatic longint blend_toward(longint prev, longint own, logic [63:0] alpha);
      longint d;
      logic [63:0] mag;
      logic [63:0] q;
      d = own - prev;
      mag = d < 0 ? -d : d;
      q = (mag >> 16) * alpha + (((mag & 64'hFFFF) * alpha + 64'd32768) >> 16);
      return d < 0 ? prev - longint'(q) : prev + longint'(q);
   endfunction

   function automatic bit link_short(longint a [3], longint b [3], logic [63:0] thr);
      logic [63:0] sum;
      logic [63:0] mag;
      longint d;
      sum = '0;
      for (int c = 0; c < 3; c++) begin
         d = a[c] - b[c];
         mag = d < 0 ? -d : d;
         if (mag >= thr) return 1'b0;
         sum += mag * mag;
      end
      return sum < thr * thr;
   endfunction

   function automatic damper_word_type predict_damper(ced_pkg::opcode_type op,
                                                      logic [31:0] px,
                                                      logic [31:0] py, logic [31:0] pz,
                                                      logic [31:0] stamp);
      damper_word_type w;
      longint pos [3];
      longint p [3];
      longint q [3];
      longint prev;
      logic [63:0] alpha;
      logic [63:0] thr;
      logic [31:0] elapsed;
      int ord;
      bit settled;
      bit moved;
      moved = 1'b0;
      pos[0] = longint'($signed(px));
      pos[1] = longint'($signed(py));
      pos[2] = longint'($signed(pz));
      if (op == ced_pkg::OP_SET_TARGET) begin
         if (pos[0] != target_pos[0] || pos[1] != target_pos[1] ||
             pos[2] != target_pos[2]) begin
            target_pos = pos;
            damping_active = 1'b1;
         end
      end else if (op == ced_pkg::OP_SET_VALUE) begin
         for (int a = 0; a < 3; a++) load_axis(a, pos[a]);
         damping_active = 1'b1;
         moved = 1'b1;
      end else if (op == ced_pkg::OP_TICK && damping_active) begin
         if (!stamp_seen) begin
            // first tick only takes the time
            stamp_seen = 1'b1;
            last_stamp = stamp;
         end else begin
            elapsed = stamp - last_stamp;
            last_stamp = stamp;
            ord = order_reg > NUM_STAGES ? NUM_STAGES : int'(order_reg);
            thr = tol_reg > TOL_FLOOR ? 64'(tol_reg) : 64'(TOL_FLOOR);
            alpha = tau_reg != 0 ? decay_factor(elapsed) : 64'd0;
            for (int i = 0; i < NUM_STAGES; i++)
               for (int a = 0; a < 3; a++) begin
                  prev = i == 0 ? target_pos[a] : stage_pos[a][i-1];
                  if (i < ord && tau_reg != 0)
                     stage_pos[a][i] = blend_toward(prev, stage_pos[a][i], alpha);
                  else
                     stage_pos[a][i] = prev;
               end
            for (int a = 0; a < 3; a++) p[a] = stage_pos[a][0];
            settled = link_short(p, target_pos, thr);
            for (int i = 1; i < ord && settled; i++) begin
               for (int a = 0; a < 3; a++) begin
                  p[a] = stage_pos[a][i];
                  q[a] = stage_pos[a][i-1];
               end
               settled = link_short(p, q, thr);
            end
            if (settled) begin
               for (int a = 0; a < 3; a++) load_axis(a, target_pos[a]);
               damping_active = 1'b0;
            end else begin
               for (int a = 0; a < 3; a++) out_pos[a] = stage_pos[a][NUM_STAGES-1];
            end
            moved = 1'b1;
         end
      end
      w.x = out_pos[0][31:0];
      w.y = out_pos[1][31:0];
      w.z = out_pos[2][31:0];
      w.active = damping_active;
      w.moved = moved;
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // request side: called at a falling edge, returns at a falling edge
   // ---------------------------------------------------------------------
   task automatic send_word(ced_pkg::opcode_type op, logic [31:0] px, logic [31:0] py,
                            logic [31:0] pz, logic [31:0] stamp,
                            logic typed, damper_word_type want);
      int gap;
      damper_word_type w;
      gap = no_idle ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.opcode = op;
      req_if.pos_x = px;
      req_if.pos_y = py;
      req_if.pos_z = pz;
      req_if.timestamp = stamp;
      do @(posedge clock); while (!req_if.ready);
      // model advances on every accepted word, typed rows override its answer
      w = predict_damper(op, px, py, pz, stamp);
      pending_words.push_back(typed ? want : w);
      @(negedge clock);
   endtask

   // all responses in, then let the sequencer settle back to idle
   task automatic drain_responses();
      req_if.valid = 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_reg(ced_pkg::reg_index_type idx, logic [31:0] data);
      csr_if.valid = 1'b1;
      csr_if.index = idx;
      csr_if.data = data;
      do @(posedge clock); while (!csr_if.ready);
      model_write_reg(idx, data);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   // mostly moderate positions so the cascade can settle, sometimes extremes
   function automatic logic [31:0] pick_position();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2: return $urandom_range(0, 200) - 100;
         default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      endcase
   endfunction

   function automatic logic [31:0] pick_elapsed();
      if (tau_reg == 0 || tau_reg > 32'h3FFF_FFFF) return $urandom;
      if ($urandom_range(0, 15) == 0) return $urandom;
      return $urandom_range(0, tau_reg * 3);
   endfunction

   // ---------------------------------------------------------------------
   // response side: random stalls, in-order compare
   // ---------------------------------------------------------------------
   initial begin
      int stall;
      damper_word_type want;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_if.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready = 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         if (pending_words.size() == 0) begin
            $error("response word with none expected");
            failed = 1'b1;
         end else begin
            want = pending_words.pop_front();
            if (rsp_if.out_x !== want.x) begin
               $error("out_x expected %h actual %h", want.x, rsp_if.out_x);
               failed = 1'b1;
            end
            if (rsp_if.out_y !== want.y) begin
               $error("out_y expected %h actual %h", want.y, rsp_if.out_y);
               failed = 1'b1;
            end
            if (rsp_if.out_z !== want.z) begin
               $error("out_z expected %h actual %h", want.z, rsp_if.out_z);
               failed = 1'b1;
            end
            if (rsp_if.is_active !== want.active) begin
               $error("is_active expected %b actual %b", want.active, rsp_if.is_active);
               failed = 1'b1;
            end
            if (rsp_if.value_event !== want.moved) begin
               $error("value_event expected %b actual %b", want.moved, rsp_if.value_event);
               failed = 1'b1;
            end
         end
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   directed_row_type directed_rows [] = '{
      // first tick after reset only records the time
      '{ced_pkg::OP_TICK, 32'd0, 32'd0, 32'd0, 32'd100, 1'b1,
        '{32'd0, 32'd0, 32'd0, 1'b1, 1'b0}},
      // unused opcode reports state
      '{ced_pkg::OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd7, 1'b1,
        '{32'd0, 32'd0, 32'd0, 1'b1, 1'b0}},
      // set value at the extremes
      '{ced_pkg::OP_SET_VALUE, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0, 1'b1,
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 1'b1, 1'b1}},
      // target equal to the old one
      '{ced_pkg::OP_SET_TARGET, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1,
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 1'b1, 1'b0}},
      '{ced_pkg::OP_SET_TARGET, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0,
        1'b0, '0},
      '{ced_pkg::OP_TICK, 32'd0, 32'd0, 32'd0, 32'd150100, 1'b0, '0},
      // zero elapsed time
      '{ced_pkg::OP_TICK, 32'd0, 32'd0, 32'd0, 32'd150100, 1'b0, '0},
      // elapsed wraps modulo 2^32
      '{ced_pkg::OP_TICK, 32'd0, 32'd0, 32'd0, 32'd5, 1'b0, '0},
      '{ced_pkg::OP_SET_VALUE, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1,
        '{32'd0, 32'd0, 32'd0, 1'b1, 1'b1}},
      '{ced_pkg::OP_SET_TARGET, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0},
      // huge elapsed: alpha zero, stages copy, cascade settles
      '{ced_pkg::OP_TICK, 32'd0, 32'd0, 32'd0, 32'h8000_0000, 1'b1,
        '{32'd0, 32'd0, 32'd0, 1'b0, 1'b1}},
      // tick while inactive changes nothing
      '{ced_pkg::OP_TICK, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b1,
        '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0}},
      '{ced_pkg::OP_NONE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'hFFFF_FFFF, 1'b1,
        '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0}},
      '{ced_pkg::OP_SET_TARGET, 32'd1, 32'd2, 32'd3, 32'd0, 1'b1,
        '{32'd0, 32'd0, 32'd0, 1'b1, 1'b0}},
      '{ced_pkg::OP_TICK, 32'd0, 32'd0, 32'd0, 32'h8000_0001, 1'b0, '0},
      '{ced_pkg::OP_TICK, 32'd0, 32'd0, 32'd0, 32'h8000_4000, 1'b0, '0}
   };

   // order, tau, tolerance, start x/y/z per phase; later phases are random
   logic [31:0] phase_regs [NUM_PHASES][6] = '{
      '{32'd3, 32'd300000, 32'd0, 32'd0, 32'd0, 32'd0},
      '{32'd5, 32'd1000, 32'd0, 32'h0001_0000, 32'hFFFF_0000, 32'd12345},
      '{32'd0, 32'd5000, 32'h0004_0000, 32'd0, 32'd0, 32'd0},
      '{32'd1, 32'd0, 32'd66, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
      '{32'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000},
      '{32'd2, 32'd1, 32'd100, 32'd0, 32'd0, 32'd0},
      '{32'd4, 32'd20000, 32'd3000, 32'd0, 32'd0, 32'd0},
      '{32'd5, 32'd2000, 32'd500, 32'd0, 32'd0, 32'd0}
   };

   initial begin
      int sent;
      int burst;
      logic [31:0] stamp;
      req_if.valid = 1'b0;
      req_if.opcode = ced_pkg::OP_TICK;
      req_if.pos_x = '0;
      req_if.pos_y = '0;
      req_if.pos_z = '0;
      req_if.timestamp = '0;
      csr_if.valid = 1'b0;
      csr_if.index = ced_pkg::REG_ORDER;
      csr_if.data = '0;
      model_reset();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed words on the reset settings
      foreach (directed_rows[r])
         send_word(directed_rows[r].op, directed_rows[r].x, directed_rows[r].y,
                   directed_rows[r].z, directed_rows[r].ts, directed_rows[r].typed,
                   directed_rows[r].want);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         drain_responses();
         if (ph >= 6) begin
            phase_regs[ph][0] = $urandom_range(0, 7);
            phase_regs[ph][1] = $urandom_range(1, 200000);
            phase_regs[ph][2] = $urandom_range(0, 5000);
            for (int a = 3; a < 6; a++) phase_regs[ph][a] = pick_position();
         end
         write_reg(ced_pkg::REG_ORDER, phase_regs[ph][0]);
         write_reg(ced_pkg::REG_TAU, phase_regs[ph][1]);
         write_reg(ced_pkg::REG_TOL, phase_regs[ph][2]);
         write_reg(ced_pkg::REG_START_X, phase_regs[ph][3]);
         write_reg(ced_pkg::REG_START_Y, phase_regs[ph][4]);
         write_reg(ced_pkg::REG_START_Z, phase_regs[ph][5]);
         // every third phase runs back to back on both sides
         no_idle = (ph % 3 == 1);
         stamp = $urandom;
         sent = 0;
         while (sent < PHASE_WORDS) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin
                  // target move followed by a run of ticks
                  send_word(ced_pkg::OP_SET_TARGET, pick_position(), pick_position(),
                            pick_position(), $urandom, 1'b0, '0);
                  burst = $urandom_range(1, 12);
                  for (int t = 0; t < burst; t++) begin
                     stamp += pick_elapsed();
                     send_word(ced_pkg::OP_TICK, $urandom, $urandom, $urandom, stamp,
                               1'b0, '0);
                  end
                  sent += burst + 1;
               end
               6: begin
                  send_word(ced_pkg::OP_SET_VALUE, pick_position(), pick_position(),
                            pick_position(), $urandom, 1'b0, '0);
                  stamp += pick_elapsed();
                  send_word(ced_pkg::OP_TICK, $urandom, $urandom, $urandom, stamp,
                            1'b0, '0);
                  sent += 2;
               end
               7: begin
                  send_word(ced_pkg::OP_NONE, $urandom, $urandom, $urandom, $urandom,
                            1'b0, '0);
                  sent++;
               end
               8: begin
                  stamp = $urandom;
                  send_word(ced_pkg::OP_TICK, $urandom, $urandom, $urandom, stamp,
                            1'b0, '0);
                  sent++;
               end
               default: begin
                  // repeat of the current target
                  send_word(ced_pkg::OP_SET_TARGET, target_pos[0][31:0],
                            target_pos[1][31:0], target_pos[2][31:0], $urandom,
                            1'b0, '0);
                  sent++;
               end
            endcase
         end
      end

      // wait for the tail, then one verdict
      req_if.valid = 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      if (!failed && pending_words.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/ced_pkg.sv
rtl/ced_if.sv
rtl/ced_ctrl.sv
rtl/ced_dp.sv
rtl/cascaded_exponential_damper_top.sv
tb/cascaded_exponential_damper_top_tb.sv
